FILE: rtl/tce_pkg.sv
// ----------------------------------------------------------------------------
// TCP connection state engine package
// Shared codes, flag constants and item/result records.
// ----------------------------------------------------------------------------
`default_nettype none

package tce_pkg;

  localparam int SLOT_COUNT_DEF = 8;
  localparam int IN_DATA_W      = 160;
  localparam int OUT_DATA_W     = 160;
  localparam int CFG_DATA_W     = 32;

  typedef enum logic [1:0] {
    OP_SEGMENT = 2'd0,
    OP_CONNECT = 2'd1,
    OP_SEND    = 2'd2,
    OP_CLOSE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    RK_TRANSMIT = 2'd0,
    RK_OPENED   = 2'd1,
    RK_DATA     = 2'd2,
    RK_REFUSED  = 2'd3
  } rkind_t;

  localparam logic [1:0] REG_LOCAL_ADDRESS = 2'd0;
  localparam logic [1:0] REG_LISTEN_ENABLE = 2'd1;
  localparam logic [1:0] REG_LSN_PORT      = 2'd2;

  localparam logic [7:0] FL_FIN = 8'h01;
  localparam logic [7:0] FL_SYN = 8'h02;
  localparam logic [7:0] FL_PSH = 8'h08;
  localparam logic [7:0] FL_ACK = 8'h10;

  localparam logic [3:0] ST_SYN_SENT   = 4'd2;
  localparam logic [3:0] ST_SYN_RCVD   = 4'd3;
  localparam logic [3:0] ST_ESTAB      = 4'd4;
  localparam logic [3:0] ST_FIN_WAIT_1 = 4'd5;
  localparam logic [3:0] ST_FIN_WAIT_2 = 4'd6;
  localparam logic [3:0] ST_CLOSE_WAIT = 4'd7;
  localparam logic [3:0] ST_LAST_ACK   = 4'd8;
  localparam logic [3:0] ST_CLOSING    = 4'd9;

  localparam logic [31:0] ISS_RESET = 32'd1000;
  localparam logic [31:0] ISS_STEP  = 32'd64000;

  typedef struct packed {
    op_t         opcode;
    logic [31:0] peer_address;
    logic [15:0] peer_port;
    logic [15:0] own_port;
    logic [31:0] seq_number;
    logic [31:0] ack_number;
    logic [7:0]  flag_bits;
    logic [15:0] payload_length;
    logic [2:0]  slot_index;
  } item_t;

  typedef struct packed {
    rkind_t      kind;
    logic [2:0]  slot;
    logic [31:0] peer_address;
    logic [15:0] peer_port;
    logic [15:0] own_port;
    logic [31:0] seq;
    logic [31:0] ack;
    logic [7:0]  flags;
    logic [15:0] length;
  } result_t;

  typedef struct packed {
    logic        listen_enable;
    logic [15:0] lsn_port;
  } listen_cfg_t;

endpackage

`default_nettype wire

FILE: rtl/tce_front.sv
// ----------------------------------------------------------------------------
// TCP engine front end
// Accepts input beats, drops bad segments and out-of-range slot commands,
// and queues the rest for the back end in a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none

module tce_front #(
  parameter int SLOT_COUNT = tce_pkg::SLOT_COUNT_DEF
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_tvalid,
  output logic                           in_tready,
  input  wire  [1:0]                     in_tuser,  // opcode
  // peer_address, peer_port, own_port, seq_number, ack_number, flag_bits,
  // payload_length, segment_ok, slot_index, zero pad
  input  wire  [tce_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                           q_valid,
  input  wire                            q_ready,
  output tce_pkg::item_t                 q_item
);
  import tce_pkg::*;

  item_t       q_mem_r [2];
  logic        wr_ptr_r, rd_ptr_r;
  logic [1:0]  cnt_r;
  item_t       it;
  logic        seg_ok;
  logic        keep;
  logic        push, pop;

  always_comb begin
    it.opcode         = op_t'(in_tuser);
    it.peer_address   = in_tdata[31:0];
    it.peer_port      = in_tdata[47:32];
    it.own_port       = in_tdata[63:48];
    it.seq_number     = in_tdata[95:64];
    it.ack_number     = in_tdata[127:96];
    it.flag_bits      = in_tdata[135:128];
    it.payload_length = in_tdata[151:136];
    it.slot_index     = in_tdata[155:153];
    seg_ok            = in_tdata[152];
    case (it.opcode)
      OP_SEGMENT: keep = seg_ok;
      OP_CONNECT: keep = 1'b1;
      OP_SEND,
      OP_CLOSE:   keep = ({4'd0, it.slot_index} < 7'(SLOT_COUNT));
      default:    keep = 1'b0;
    endcase
  end

  assign in_tready = (cnt_r != 2'd2);
  assign q_valid   = (cnt_r != 2'd0);
  assign q_item    = q_mem_r[rd_ptr_r];
  assign push      = in_tvalid && in_tready && keep;
  assign pop       = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop) rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_mem_r[wr_ptr_r] <= it;
  end

endmodule

`default_nettype wire

FILE: rtl/tce_back.sv
// ----------------------------------------------------------------------------
// TCP engine back end
// Scans the slot table, applies the per-state rules in a read-modify-write
// of one slot and emits the result beats through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tce_back #(
  parameter int SLOT_COUNT = tce_pkg::SLOT_COUNT_DEF
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             q_valid,
  output logic                            q_ready,
  input  tce_pkg::item_t                  q_item,
  input  tce_pkg::listen_cfg_t            lcfg,
  output logic                            out_tvalid,
  input  wire                             out_tready,
  output logic [1:0]                      out_tuser,  // result_kind
  // result_slot, out_peer_address, out_peer_port, out_own_port, out_seq,
  // out_ack, out_flags, out_length, zero pad
  output logic [tce_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic                            out_tlast
);
  import tce_pkg::*;

  localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  typedef struct packed {
    logic [3:0]  state;
    logic [15:0] own_port;
    logic [31:0] peer_address;
    logic [15:0] peer_port;
    logic [31:0] snd_nxt;
    logic [31:0] rcv_nxt;
  } slot_rec_t;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CHECK = 4'b0010,
    S_EXEC  = 4'b0100,
    S_EMIT  = 4'b1000
  } bstate_t;

  function automatic result_t mk(rkind_t k, logic [2:0] s, logic [31:0] a,
                                 logic [15:0] pp, logic [15:0] op, logic [31:0] sq,
                                 logic [31:0] ak, logic [7:0] f, logic [15:0] l);
    result_t r;
    r.kind = k; r.slot = s; r.peer_address = a; r.peer_port = pp; r.own_port = op;
    r.seq = sq; r.ack = ak; r.flags = f; r.length = l;
    return r;
  endfunction

  slot_rec_t             mem [SLOT_COUNT];
  slot_rec_t             mem_q;
  slot_rec_t             d;
  bstate_t               st_r, st_nxt;
  item_t                 item_r, item_nxt;
  logic [SW-1:0]         scan_r, scan_nxt;
  logic                  direct_r, direct_nxt;
  logic                  matched_r, matched_nxt;
  logic [SLOT_COUNT-1:0] in_use_r, in_use_nxt;
  logic [31:0]           isc_r;
  result_t               res_r [3];
  result_t               res_nxt [3];
  logic [1:0]            cnt_r, cnt_nxt;
  logic [1:0]            k_r;
  result_t               out_r;
  logic                  out_valid_r, out_last_r;
  logic                  push, emit_last;
  logic                  hit;
  logic                  wr_en, set_use, clr_use, isc_adv;
  logic [SW-1:0]         wr_idx;
  slot_rec_t             wr_rec;
  logic                  free_found;
  logic [SW-1:0]         free_idx;
  logic                  f_ack, f_syn, f_fin, ackok, c1, c2, fin_eq;
  logic [31:0]           sum, rcv1, rcv2, rcv_inc;
  logic [2:0]            s3;

  assign d = mem_q;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_idx] <= wr_rec;
    mem_q <= mem[scan_nxt];
  end

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!in_use_r[i]) begin
        free_found = 1'b1;
        free_idx   = SW'(i);
      end
    end
  end

  assign hit = in_use_r[scan_r] && d.peer_address == item_r.peer_address &&
               d.peer_port == item_r.peer_port && d.own_port == item_r.own_port;

  assign q_ready = (st_r == S_IDLE);

  always_comb begin
    st_nxt      = st_r;
    item_nxt    = item_r;
    scan_nxt    = scan_r;
    direct_nxt  = direct_r;
    matched_nxt = matched_r;
    case (st_r)
      S_IDLE: begin
        if (q_valid) begin
          item_nxt = q_item;
          case (q_item.opcode)
            OP_SEGMENT: begin
              scan_nxt   = '0;
              direct_nxt = 1'b0;
              st_nxt     = S_CHECK;
            end
            OP_CONNECT: st_nxt = S_EXEC;
            default: begin
              if (in_use_r[SW'(q_item.slot_index)]) begin
                scan_nxt   = SW'(q_item.slot_index);
                direct_nxt = 1'b1;
                st_nxt     = S_CHECK;
              end
            end
          endcase
        end
      end
      S_CHECK: begin
        if (direct_r || hit) begin
          matched_nxt = 1'b1;
          st_nxt      = S_EXEC;
        end else if (scan_r == SW'(SLOT_COUNT - 1)) begin
          matched_nxt = 1'b0;
          st_nxt      = S_EXEC;
        end else begin
          scan_nxt = scan_r + SW'(1);
        end
      end
      S_EXEC: st_nxt = (cnt_nxt != 2'd0) ? S_EMIT : S_IDLE;
      S_EMIT: if (push && emit_last) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  // per-state rules
  always_comb begin
    f_ack   = (item_r.flag_bits & FL_ACK) != 8'd0;
    f_syn   = (item_r.flag_bits & FL_SYN) != 8'd0;
    f_fin   = (item_r.flag_bits & FL_FIN) != 8'd0;
    ackok   = f_ack && (item_r.ack_number == d.snd_nxt);
    sum     = item_r.seq_number + 32'(item_r.payload_length);
    c1      = (item_r.payload_length != 16'd0) && (item_r.seq_number == d.rcv_nxt);
    c2      = f_fin && (c1 || (sum == d.rcv_nxt));
    rcv1    = c1 ? sum : d.rcv_nxt;
    rcv2    = rcv1 + 32'd1;
    fin_eq  = f_fin && (item_r.seq_number == d.rcv_nxt);
    rcv_inc = d.rcv_nxt + 32'd1;
    s3      = 3'(scan_r);
    wr_en   = 1'b0;
    wr_idx  = scan_r;
    wr_rec  = d;
    set_use = 1'b0;
    clr_use = 1'b0;
    isc_adv = 1'b0;
    cnt_nxt = 2'd0;
    for (int j = 0; j < 3; j++) res_nxt[j] = '0;
    if (st_r == S_EXEC) begin
      case (item_r.opcode)
        OP_CONNECT: begin
          if (!free_found) begin
            res_nxt[0] = mk(RK_REFUSED, 3'd0, item_r.peer_address, item_r.peer_port,
                            item_r.own_port, 32'd0, 32'd0, 8'd0, 16'd0);
          end else begin
            wr_en   = 1'b1;
            wr_idx  = free_idx;
            wr_rec  = '{ST_SYN_SENT, item_r.own_port, item_r.peer_address,
                        item_r.peer_port, isc_r + 32'd1, 32'd0};
            set_use = 1'b1;
            isc_adv = 1'b1;
            res_nxt[0] = mk(RK_TRANSMIT, 3'(free_idx), item_r.peer_address,
                            item_r.peer_port, item_r.own_port, isc_r, 32'd0,
                            FL_SYN, 16'd0);
          end
          cnt_nxt = 2'd1;
        end
        OP_SEGMENT: begin
          if (!matched_r) begin
            if (f_syn && !f_ack && lcfg.listen_enable &&
                item_r.own_port == lcfg.lsn_port && free_found) begin
              wr_en   = 1'b1;
              wr_idx  = free_idx;
              wr_rec  = '{ST_SYN_RCVD, item_r.own_port, item_r.peer_address,
                          item_r.peer_port, isc_r + 32'd1, item_r.seq_number + 32'd1};
              set_use = 1'b1;
              isc_adv = 1'b1;
              res_nxt[0] = mk(RK_TRANSMIT, 3'(free_idx), item_r.peer_address,
                              item_r.peer_port, item_r.own_port, isc_r,
                              item_r.seq_number + 32'd1, FL_SYN | FL_ACK, 16'd0);
              cnt_nxt = 2'd1;
            end
          end else begin
            wr_en = 1'b1;
            case (d.state)
              ST_SYN_SENT: begin
                if (f_syn && ackok) begin
                  wr_rec.rcv_nxt = item_r.seq_number + 32'd1;
                  wr_rec.state   = ST_ESTAB;
                  res_nxt[0] = mk(RK_TRANSMIT, s3, d.peer_address, d.peer_port,
                                  d.own_port, d.snd_nxt, item_r.seq_number + 32'd1,
                                  FL_ACK, 16'd0);
                  res_nxt[1] = mk(RK_OPENED, s3, d.peer_address, d.peer_port,
                                  d.own_port, 32'd0, 32'd0, 8'd0, 16'd0);
                  cnt_nxt = 2'd2;
                end
              end
              ST_SYN_RCVD: begin
                if (ackok) begin
                  wr_rec.state = ST_ESTAB;
                  res_nxt[0] = mk(RK_OPENED, s3, d.peer_address, d.peer_port,
                                  d.own_port, 32'd0, 32'd0, 8'd0, 16'd0);
                  cnt_nxt = 2'd1;
                end
              end
              ST_ESTAB: begin
                wr_rec.rcv_nxt = c2 ? rcv2 : rcv1;
                if (c1) begin
                  res_nxt[cnt_nxt] = mk(RK_TRANSMIT, s3, d.peer_address, d.peer_port,
                                        d.own_port, d.snd_nxt, rcv1, FL_ACK, 16'd0);
                  cnt_nxt = cnt_nxt + 2'd1;
                  res_nxt[cnt_nxt] = mk(RK_DATA, s3, d.peer_address, d.peer_port,
                                        d.own_port, 32'd0, 32'd0, 8'd0,
                                        item_r.payload_length);
                  cnt_nxt = cnt_nxt + 2'd1;
                end
                if (c2) begin
                  wr_rec.state = ST_CLOSE_WAIT;
                  res_nxt[cnt_nxt] = mk(RK_TRANSMIT, s3, d.peer_address, d.peer_port,
                                        d.own_port, d.snd_nxt, rcv2, FL_ACK, 16'd0);
                  cnt_nxt = cnt_nxt + 2'd1;
                end
              end
              ST_FIN_WAIT_1: begin
                if (ackok) wr_rec.state = ST_FIN_WAIT_2;
                if (fin_eq) begin
                  wr_rec.rcv_nxt = rcv_inc;
                  res_nxt[0] = mk(RK_TRANSMIT, s3, d.peer_address, d.peer_port,
                                  d.own_port, d.snd_nxt, rcv_inc, FL_ACK, 16'd0);
                  cnt_nxt = 2'd1;
                  if (ackok) clr_use = 1'b1;
                  else wr_rec.state = ST_CLOSING;
                end
              end
              ST_FIN_WAIT_2: begin
                if (fin_eq) begin
                  wr_rec.rcv_nxt = rcv_inc;
                  res_nxt[0] = mk(RK_TRANSMIT, s3, d.peer_address, d.peer_port,
                                  d.own_port, d.snd_nxt, rcv_inc, FL_ACK, 16'd0);
                  cnt_nxt = 2'd1;
                  clr_use = 1'b1;
                end
              end
              ST_CLOSING,
              ST_LAST_ACK: if (ackok) clr_use = 1'b1;
              default: wr_en = 1'b0;
            endcase
          end
        end
        OP_SEND: begin
          if (d.state == ST_ESTAB || d.state == ST_CLOSE_WAIT) begin
            wr_en          = 1'b1;
            wr_rec.snd_nxt = d.snd_nxt + 32'(item_r.payload_length);
            res_nxt[0] = mk(RK_TRANSMIT, s3, d.peer_address, d.peer_port, d.own_port,
                            d.snd_nxt, d.rcv_nxt, FL_PSH | FL_ACK, item_r.payload_length);
            cnt_nxt = 2'd1;
          end
        end
        default: begin
          if (d.state == ST_ESTAB || d.state == ST_CLOSE_WAIT) begin
            wr_en          = 1'b1;
            wr_rec.snd_nxt = d.snd_nxt + 32'd1;
            wr_rec.state   = (d.state == ST_ESTAB) ? ST_FIN_WAIT_1 : ST_LAST_ACK;
            res_nxt[0] = mk(RK_TRANSMIT, s3, d.peer_address, d.peer_port, d.own_port,
                            d.snd_nxt, d.rcv_nxt, FL_FIN | FL_ACK, 16'd0);
            cnt_nxt = 2'd1;
          end
        end
      endcase
    end
  end

  always_comb begin
    in_use_nxt = in_use_r;
    if (set_use) in_use_nxt[wr_idx] = 1'b1;
    if (clr_use) in_use_nxt[scan_r] = 1'b0;
  end

  assign push      = (st_r == S_EMIT) && (!out_valid_r || out_tready);
  assign emit_last = (k_r == cnt_r - 2'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      in_use_r    <= '0;
      isc_r       <= ISS_RESET;
      out_valid_r <= 1'b0;
      cnt_r       <= 2'd0;
      k_r         <= 2'd0;
    end else begin
      st_r     <= st_nxt;
      in_use_r <= in_use_nxt;
      if (isc_adv) isc_r <= isc_r + ISS_STEP;
      if (st_r == S_EXEC) begin
        cnt_r <= cnt_nxt;
        k_r   <= 2'd0;
      end else if (push) begin
        k_r <= k_r + 2'd1;
      end
      if (push) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    item_r    <= item_nxt;
    scan_r    <= scan_nxt;
    direct_r  <= direct_nxt;
    matched_r <= matched_nxt;
    if (st_r == S_EXEC) begin
      for (int j = 0; j < 3; j++) res_r[j] <= res_nxt[j];
    end
    if (push) begin
      out_r      <= res_r[k_r];
      out_last_r <= emit_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.kind;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {5'd0, out_r.length, out_r.flags, out_r.ack, out_r.seq,
                       out_r.own_port, out_r.peer_port, out_r.peer_address, out_r.slot};

  a_emit_has_results: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_EMIT) |-> (cnt_r != 2'd0))
    else $error("emit state with no pending results");

  a_exec_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_EXEC) |=> (st_r == S_EMIT || st_r == S_IDLE))
    else $error("exec did not finish in one cycle");

  a_push_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (k_r < cnt_r))
    else $error("result index past result count");

  a_take_slot: assert property (@(posedge clk) disable iff (!rst_n)
    set_use |=> ($countones(in_use_r) == $past($countones(in_use_r)) + 1))
    else $error("slot allocation did not mark exactly one slot");

endmodule

`default_nettype wire

FILE: rtl/tcp_connection_state_engine.sv
// ----------------------------------------------------------------------------
// TCP connection state engine
// A segment is dequeued, the slot table is scanned until a match or the last
// slot (one slot-table read per cycle), the slot is updated and the results are
// emitted one per cycle while the receiver is ready. Connect skips the scan; send
// and close read their slot directly. A new item is taken after the last result.
// Reset (rst_n, synchronous): all slots free, sequence clock 1000, listen off.
// ----------------------------------------------------------------------------
`default_nettype none

module tcp_connection_state_engine #(
  parameter int SLOT_COUNT = tce_pkg::SLOT_COUNT_DEF
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_tvalid,
  output logic                             in_tready,
  input  wire  [1:0]                       in_tuser,  // opcode
  // peer_address, peer_port, own_port, seq_number, ack_number, flag_bits,
  // payload_length, segment_ok, slot_index, zero pad
  input  wire  [tce_pkg::IN_DATA_W-1:0]    in_tdata,
  output logic                             out_tvalid,
  input  wire                              out_tready,
  output logic [1:0]                       out_tuser,  // result_kind
  // result_slot, out_peer_address, out_peer_port, out_own_port, out_seq,
  // out_ack, out_flags, out_length, zero pad
  output logic [tce_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                             out_tlast,
  input  wire                              cfg_wr_en,
  input  wire  [1:0]                       cfg_index,
  input  wire  [tce_pkg::CFG_DATA_W-1:0]   cfg_wr_data
);
  import tce_pkg::*;

  logic        listen_enable_r;
  logic [15:0] lsn_port_r;
  listen_cfg_t lcfg;
  logic        q_valid, q_ready;
  item_t       q_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      listen_enable_r <= 1'b0;
      lsn_port_r      <= 16'd0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_LISTEN_ENABLE: listen_enable_r <= cfg_wr_data[0];
        REG_LSN_PORT:      lsn_port_r      <= cfg_wr_data[15:0];
        // own address is not stored here; writes to it have no effect
        REG_LOCAL_ADDRESS: begin
        end
        default: begin
        end
      endcase
    end
  end

  assign lcfg.listen_enable = listen_enable_r;
  assign lcfg.lsn_port      = lsn_port_r;

  tce_front #(.SLOT_COUNT(SLOT_COUNT)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item)
  );

  tce_back #(.SLOT_COUNT(SLOT_COUNT)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_item     (q_item),
    .lcfg       (lcfg),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

FILE: dv/tb_tcp_connection_state_engine.sv
// ----------------------------------------------------------------------------
// TCP connection state engine testbench
// Drives segment, connect, send and close beats into the engine, predicts the
// result beats from an own model of the slot table and compares every field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_tcp_connection_state_engine;
  import tce_pkg::*;

  localparam int NSLOT = 8;
  localparam logic [3:0] ST_CLOSED = 4'd0;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    result_t r;
    bit      last;
  } expected_t;

  class conn_scoreboard;
    logic [31:0] local_addr;
    bit          listen_en;
    logic [15:0] lsn_port;
    bit          in_use [NSLOT];
    logic [3:0]  cstate [NSLOT];
    logic [15:0] own_port [NSLOT];
    logic [31:0] peer_addr [NSLOT];
    logic [15:0] peer_port [NSLOT];
    logic [31:0] snd_nxt [NSLOT];
    logic [31:0] rcv_nxt [NSLOT];
    logic [31:0] seq_clock;
    expected_t   pending [$];
    expected_t   step_res [$];
    int          errors;
    int          n_results;
    int          n_refused;

    function new();
      local_addr = 0;
      listen_en = 0;
      lsn_port = 0;
      seq_clock = ISS_RESET;
      for (int i = 0; i < NSLOT; i++) begin
        in_use[i] = 0;
        cstate[i] = ST_CLOSED;
      end
    endfunction

    function void emit(rkind_t k, int s, logic [31:0] a, logic [15:0] pp, logic [15:0] op,
                       logic [31:0] sq, logic [31:0] ak, logic [7:0] fl, logic [15:0] ln);
      expected_t e;
      if (step_res.size() >= 3) return;
      e.r.kind = k;
      e.r.slot = s[2:0];
      e.r.peer_address = a;
      e.r.peer_port = pp;
      e.r.own_port = op;
      e.r.seq = sq;
      e.r.ack = ak;
      e.r.flags = fl;
      e.r.length = ln;
      e.last = 0;
      step_res.push_back(e);
    endfunction

    function void transmit(int s, logic [7:0] fl, logic [15:0] ln);
      emit(RK_TRANSMIT, s, peer_addr[s], peer_port[s], own_port[s], snd_nxt[s], rcv_nxt[s],
           fl, ln);
      snd_nxt[s] += 32'(ln) + ((fl & FL_SYN) != 0) + ((fl & FL_FIN) != 0);
    endfunction

    function void notify(int s, rkind_t k, logic [15:0] ln);
      emit(k, s, peer_addr[s], peer_port[s], own_port[s], 0, 0, 0, ln);
    endfunction

    function int take_slot(logic [31:0] a, logic [15:0] pp, logic [15:0] op);
      for (int i = 0; i < NSLOT; i++) begin
        if (!in_use[i]) begin
          in_use[i] = 1;
          own_port[i] = op;
          peer_addr[i] = a;
          peer_port[i] = pp;
          rcv_nxt[i] = 0;
          snd_nxt[i] = seq_clock;
          seq_clock += ISS_STEP;
          return i;
        end
      end
      return -1;
    endfunction

    function void release_slot(int s);
      in_use[s] = 0;
      cstate[s] = ST_CLOSED;
    endfunction

    function void segment(item_t it);
      int s;
      bit ack_ok;
      logic [7:0] fl;
      s = -1;
      fl = it.flag_bits;
      for (int i = 0; i < NSLOT; i++)
        if (s < 0 && in_use[i] && peer_addr[i] == it.peer_address &&
            peer_port[i] == it.peer_port && own_port[i] == it.own_port) s = i;
      if (s < 0) begin
        if ((fl & FL_SYN) && !(fl & FL_ACK) && listen_en && it.own_port == lsn_port) begin
          s = take_slot(it.peer_address, it.peer_port, it.own_port);
          if (s < 0) return;
          rcv_nxt[s] = it.seq_number + 1;
          cstate[s] = ST_SYN_RCVD;
          transmit(s, FL_SYN | FL_ACK, 0);
        end
        return;
      end
      ack_ok = (fl & FL_ACK) != 0 && it.ack_number == snd_nxt[s];
      case (cstate[s])
        ST_SYN_SENT: begin
          if ((fl & FL_SYN) && ack_ok) begin
            rcv_nxt[s] = it.seq_number + 1;
            cstate[s] = ST_ESTAB;
            transmit(s, FL_ACK, 0);
            notify(s, RK_OPENED, 0);
          end
        end
        ST_SYN_RCVD: begin
          if (ack_ok) begin
            cstate[s] = ST_ESTAB;
            notify(s, RK_OPENED, 0);
          end
        end
        ST_ESTAB: begin
          if (it.payload_length > 0 && it.seq_number == rcv_nxt[s]) begin
            rcv_nxt[s] += 32'(it.payload_length);
            transmit(s, FL_ACK, 0);
            notify(s, RK_DATA, it.payload_length);
          end
          if ((fl & FL_FIN) && it.seq_number + 32'(it.payload_length) == rcv_nxt[s]) begin
            rcv_nxt[s] += 1;
            transmit(s, FL_ACK, 0);
            cstate[s] = ST_CLOSE_WAIT;
          end
        end
        ST_FIN_WAIT_1: begin
          if (ack_ok) cstate[s] = ST_FIN_WAIT_2;
          if ((fl & FL_FIN) && it.seq_number == rcv_nxt[s]) begin
            rcv_nxt[s] += 1;
            transmit(s, FL_ACK, 0);
            if (cstate[s] == ST_FIN_WAIT_2) release_slot(s);
            else cstate[s] = ST_CLOSING;
          end
        end
        ST_FIN_WAIT_2: begin
          if ((fl & FL_FIN) && it.seq_number == rcv_nxt[s]) begin
            rcv_nxt[s] += 1;
            transmit(s, FL_ACK, 0);
            release_slot(s);
          end
        end
        ST_CLOSING, ST_LAST_ACK: begin
          if (ack_ok) release_slot(s);
        end
        default: ;
      endcase
    endfunction

    function void note_item(item_t it, bit ok);
      int s;
      step_res.delete();
      case (it.opcode)
        OP_SEGMENT: if (ok) segment(it);
        OP_CONNECT: begin
          s = take_slot(it.peer_address, it.peer_port, it.own_port);
          if (s < 0) emit(RK_REFUSED, 0, it.peer_address, it.peer_port, it.own_port, 0, 0, 0, 0);
          else begin
            cstate[s] = ST_SYN_SENT;
            transmit(s, FL_SYN, 0);
          end
        end
        default: begin
          s = it.slot_index;
          if (in_use[s]) begin
            if (it.opcode == OP_SEND) begin
              if (cstate[s] == ST_ESTAB || cstate[s] == ST_CLOSE_WAIT)
                transmit(s, FL_PSH | FL_ACK, it.payload_length);
            end else if (cstate[s] == ST_ESTAB) begin
              transmit(s, FL_FIN | FL_ACK, 0);
              cstate[s] = ST_FIN_WAIT_1;
            end else if (cstate[s] == ST_CLOSE_WAIT) begin
              transmit(s, FL_FIN | FL_ACK, 0);
              cstate[s] = ST_LAST_ACK;
            end
          end
        end
      endcase
      if (step_res.size() > 0) step_res[step_res.size() - 1].last = 1;
      foreach (step_res[i]) pending.push_back(step_res[i]);
    endfunction

    function void compare(string name, logic [63:0] e, logic [63:0] a);
      if (e !== a) begin
        $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, e, a);
        errors++;
      end
    endfunction

    function void check_result(logic [1:0] kind, logic [OUT_DATA_W-1:0] d, logic last);
      expected_t e;
      if (pending.size() == 0) begin
        $error("unexpected result beat: kind %0d data 0x%0h", kind, d);
        errors++;
        return;
      end
      e = pending.pop_front();
      n_results++;
      if (e.r.kind == RK_REFUSED) n_refused++;
      compare("result_kind", e.r.kind, kind);
      compare("result_slot", e.r.slot, d[2:0]);
      compare("out_peer_address", e.r.peer_address, d[34:3]);
      compare("out_peer_port", e.r.peer_port, d[50:35]);
      compare("out_own_port", e.r.own_port, d[66:51]);
      compare("out_seq", e.r.seq, d[98:67]);
      compare("out_ack", e.r.ack, d[130:99]);
      compare("out_flags", e.r.flags, d[138:131]);
      compare("out_length", e.r.length, d[154:139]);
      compare("last_result", e.last, last);
      compare("pad", 0, d[159:155]);
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [1:0] in_tuser;
  logic [IN_DATA_W-1:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [1:0] out_tuser;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic out_tlast;
  logic cfg_wr_en;
  logic [1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wr_data;

  conn_scoreboard sb = new();
  bit idle_on = 1;
  bit hold_req = 0;
  int n_items = 0;
  int cycles = 0;

  tcp_connection_state_engine dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tuser(in_tuser), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tuser(out_tuser),
    .out_tdata(out_tdata), .out_tlast(out_tlast),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver: random stalls plus one long hold-off on request
  initial begin
    int n;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_req = 0;
        out_tready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 3);
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
      @(posedge clk);
    end
  end

  always begin
    logic hs;
    logic [1:0] k;
    logic [OUT_DATA_W-1:0] d;
    logic l;
    @(negedge clk);
    hs = out_tvalid && out_tready && rst_n;
    k = out_tuser;
    d = out_tdata;
    l = out_tlast;
    @(posedge clk);
    if (hs) sb.check_result(k, d, l);
  end

  function automatic logic [IN_DATA_W-1:0] pack_item(item_t it, bit ok);
    logic [IN_DATA_W-1:0] d;
    d = '0;
    d[31:0] = it.peer_address;
    d[47:32] = it.peer_port;
    d[63:48] = it.own_port;
    d[95:64] = it.seq_number;
    d[127:96] = it.ack_number;
    d[135:128] = it.flag_bits;
    d[151:136] = it.payload_length;
    d[152] = ok;
    d[155:153] = it.slot_index;
    return d;
  endfunction

  task automatic drive_item(item_t it, bit ok);
    logic rdy;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= it.opcode;
    in_tdata <= pack_item(it, ok);
    forever begin
      @(negedge clk);
      rdy = in_tready;
      @(posedge clk);
      if (rdy) break;
    end
    sb.note_item(it, ok);
    n_items++;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wr_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_LOCAL_ADDRESS: sb.local_addr = val;
      REG_LISTEN_ENABLE: sb.listen_en = val[0];
      default: sb.lsn_port = val[15:0];
    endcase
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (3 * NSLOT + 20) @(posedge clk);
  endtask

  function automatic item_t blank_item(op_t op);
    item_t it;
    it = '0;
    it.opcode = op;
    return it;
  endfunction

  function automatic item_t seg_for(int s, logic [7:0] fl, logic [15:0] ln);
    item_t it;
    it = blank_item(OP_SEGMENT);
    it.peer_address = sb.peer_addr[s];
    it.peer_port = sb.peer_port[s];
    it.own_port = sb.own_port[s];
    it.seq_number = sb.rcv_nxt[s];
    it.ack_number = sb.snd_nxt[s];
    it.flag_bits = fl;
    it.payload_length = ln;
    return it;
  endfunction

  function automatic item_t cmd_item(op_t op, int s, logic [15:0] ln);
    item_t it;
    it = blank_item(op);
    it.slot_index = s[2:0];
    it.payload_length = ln;
    return it;
  endfunction

  function automatic item_t conn_item(logic [31:0] a, logic [15:0] pp, logic [15:0] op);
    item_t it;
    it = blank_item(OP_CONNECT);
    it.peer_address = a;
    it.peer_port = pp;
    it.own_port = op;
    return it;
  endfunction

  // well-formed segment for a live slot, sometimes off by one
  function automatic item_t live_segment(int s);
    item_t it;
    logic [7:0] fl;
    logic [15:0] ln;
    ln = 0;
    case (sb.cstate[s])
      ST_SYN_SENT: fl = FL_SYN | FL_ACK;
      ST_ESTAB: begin
        fl = FL_ACK | ($urandom_range(0, 1) ? FL_PSH : 8'h00) |
             ($urandom_range(0, 3) == 0 ? FL_FIN : 8'h00);
        ln = $urandom_range(0, 2) == 0 ? 16'd0 : 16'($urandom_range(1, 1500));
      end
      ST_FIN_WAIT_1: fl = ($urandom_range(0, 1) ? FL_ACK : 8'h00) |
                          ($urandom_range(0, 1) ? FL_FIN : 8'h00);
      ST_FIN_WAIT_2: fl = FL_FIN | FL_ACK;
      default: fl = FL_ACK;
    endcase
    it = seg_for(s, fl, ln);
    if (sb.cstate[s] == ST_SYN_SENT) it.seq_number = $urandom;
    if ($urandom_range(0, 9) == 0) it.seq_number += 1;
    if ($urandom_range(0, 9) == 0) it.ack_number -= 1;
    return it;
  endfunction

  task automatic random_item();
    item_t it;
    bit ok;
    int r;
    int s;
    int live [$];
    logic [191:0] rnd;
    ok = 1;
    r = $urandom_range(0, 99);
    for (int i = 0; i < NSLOT; i++) if (sb.in_use[i]) live.push_back(i);
    if (r < 8) begin
      rnd = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      it = item_t'(rnd[$bits(item_t)-1:0]);
      ok = 1'($urandom_range(0, 1));
    end else if (r < 18 || (r >= 50 && live.size() == 0)) begin
      it = conn_item($urandom, 16'($urandom), 16'($urandom));
    end else if (r < 28) begin
      it = blank_item(OP_SEGMENT);
      it.peer_address = $urandom;
      it.peer_port = 16'($urandom);
      it.own_port = $urandom_range(0, 4) == 0 ? 16'($urandom) : sb.lsn_port;
      it.seq_number = $urandom;
      it.flag_bits = FL_SYN | ($urandom_range(0, 5) == 0 ? FL_ACK : 8'h00);
    end else if (r < 40) begin
      it = cmd_item(OP_SEND, $urandom_range(0, NSLOT - 1), $urandom_range(0, 3) == 0 ?
                    16'($urandom) : 16'($urandom_range(0, 1500)));
    end else if (r < 50) begin
      it = cmd_item(OP_CLOSE, $urandom_range(0, NSLOT - 1), 0);
    end else begin
      s = live[$urandom_range(0, live.size() - 1)];
      it = live_segment(s);
      if ($urandom_range(0, 19) == 0) ok = 0;
    end
    drive_item(it, ok);
  endtask

  initial begin
    item_t it;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tuser <= '0;
    in_tdata <= '0;
    cfg_wr_en <= 1'b0;
    cfg_index <= '0;
    cfg_wr_data <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_reg(REG_LOCAL_ADDRESS, 32'hFFFF_FFFF);
    write_reg(REG_LISTEN_ENABLE, 32'd1);
    write_reg(REG_LSN_PORT, 32'd80);

    // active open, data both ways, peer close, own close
    drive_item(conn_item(32'hFFFF_FFFF, 16'hFFFF, 16'h0000), 1);
    it = seg_for(0, FL_SYN | FL_ACK, 0);
    it.seq_number = 32'hFFFF_FFFF;
    drive_item(it, 1);
    drive_item(seg_for(0, FL_ACK | FL_PSH, 16'hFFFF), 0);
    drive_item(seg_for(0, FL_ACK | FL_PSH, 16'hFFFF), 1);
    drive_item(cmd_item(OP_SEND, 0, 16'hFFFF), 1);
    drive_item(seg_for(0, FL_FIN | FL_ACK, 16'd10), 1);
    drive_item(cmd_item(OP_SEND, 0, 16'd0), 1);
    drive_item(cmd_item(OP_CLOSE, 0, 0), 1);
    drive_item(seg_for(0, FL_ACK, 0), 1);
    // passive open, then close with simultaneous FIN and ACK
    it = blank_item(OP_SEGMENT);
    it.own_port = 16'd80;
    it.flag_bits = FL_SYN;
    drive_item(it, 1);
    drive_item(seg_for(0, FL_ACK, 0), 1);
    drive_item(cmd_item(OP_CLOSE, 0, 0), 1);
    drive_item(seg_for(0, FL_FIN | FL_ACK, 0), 1);
    // close through closing, then a send to a free slot
    drive_item(conn_item(32'h0A00_0001, 16'd1, 16'hFFFF), 1);
    drive_item(cmd_item(OP_CLOSE, 0, 0), 1);
    drive_item(seg_for(0, FL_SYN | FL_ACK, 0), 1);
    drive_item(cmd_item(OP_CLOSE, 0, 0), 1);
    drive_item(seg_for(0, FL_FIN, 0), 1);
    drive_item(seg_for(0, FL_ACK, 0), 1);
    drive_item(cmd_item(OP_SEND, 5, 16'd7), 1);
    // fill the table, then overflow by connect and passive SYN
    for (int i = 0; i < NSLOT + 1; i++)
      drive_item(conn_item(32'hC0A8_0000 + i, 16'(1000 + i), 16'(2000 + i)), 1);
    it.peer_address = 32'h0B00_0000;
    drive_item(it, 1);
    drain();

    write_reg(REG_LSN_PORT, 32'hFFFF);
    write_reg(REG_LOCAL_ADDRESS, 32'h0000_0000);
    for (int i = 0; i < 150; i++) begin
      if (i == 60) hold_req = 1;
      random_item();
    end
    drain();

    write_reg(REG_LSN_PORT, 32'h0000);
    for (int i = 0; i < 120; i++) random_item();
    drain();

    write_reg(REG_LISTEN_ENABLE, 32'd0);
    write_reg(REG_LSN_PORT, 32'd443);
    write_reg(REG_LOCAL_ADDRESS, 32'h8000_0001);
    for (int i = 0; i < 40; i++) random_item();
    drain();
    write_reg(REG_LISTEN_ENABLE, 32'd1);
    idle_on = 0;
    for (int i = 0; i < 90; i++) random_item();
    drain();

    $display("Run covered %0d input beats and %0d result beats (%0d refusals).",
             n_items, sb.n_results, sb.n_refused);
    $display("Listen settings stepped through ports 80, 65535, 0 and 443, on and off.");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      if (sb.pending.size() != 0) $error("%0d expected results never arrived", sb.pending.size());
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
